FILE: rtl/core/stok_pkg.sv
package stok_pkg;

   // storage widths of the scanner counters
   localparam int LENGTH_BITS = 16;
   localparam int OFFSET_BITS = 32;
   localparam int OUT_LEN_MAX = 65535;

   localparam logic [30:0] VAL_MAX = '1;

   // token kinds
   localparam logic [5:0] KIND_LPAREN = 6'd0;
   localparam logic [5:0] KIND_RPAREN = 6'd1;
   localparam logic [5:0] KIND_LBRACE = 6'd2;
   localparam logic [5:0] KIND_RBRACE = 6'd3;
   localparam logic [5:0] KIND_COMMA  = 6'd4;
   localparam logic [5:0] KIND_SEMI   = 6'd5;
   localparam logic [5:0] KIND_POINT  = 6'd6;
   localparam logic [4:0] OP_PLUS     = 5'd7;
   localparam logic [4:0] OP_MINUS    = 5'd9;
   localparam logic [4:0] OP_STAR     = 5'd11;
   localparam logic [5:0] KIND_DIV    = 6'd13;
   localparam logic [4:0] OP_PERCENT  = 5'd15;
   localparam logic [4:0] OP_CARET    = 5'd17;
   localparam logic [4:0] OP_AMP      = 5'd19;
   localparam logic [4:0] OP_BAR      = 5'd21;
   localparam logic [4:0] OP_LESS     = 5'd23;
   localparam logic [4:0] OP_GREATER  = 5'd25;
   localparam logic [4:0] OP_ASSIGN   = 5'd27;
   localparam logic [4:0] OP_BANG     = 5'd29;
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [5:0] KIND_STRING = 6'd31;
   localparam logic [5:0] KIND_INT    = 6'd32;
   localparam logic [5:0] KIND_FLOAT  = 6'd33;
   localparam logic [5:0] KIND_IDENT  = 6'd34;
   localparam logic [5:0] KIND_KW0    = 6'd35;
   localparam logic [5:0] KIND_EOF    = 6'd44;
   localparam logic [5:0] KIND_ERROR  = 6'd45;

   // keywords packed right-aligned, first byte most significant
   localparam int KW_COUNT = 9;
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'h0063_6C61_7373,  // class
      48'h0077_6869_6C65,  // while
      48'h0000_0066_6F72,  // for
      48'h0000_0000_6966,  // if
      48'h0000_656C_7365,  // else
      48'h7265_7475_726E,  // return
      48'h0000_6E75_6C6C,  // null
      48'h0000_7472_7565,  // true
      48'h0066_616C_7365   // false
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd5, 3'd3, 3'd2, 3'd4, 3'd6, 3'd4, 3'd4, 3'd5
   };

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_OPER,
      PH_SLASH,
      PH_COMMENT,
      PH_STRING,
      PH_INT,
      PH_INTDOT,
      PH_FLOAT,
      PH_IDENT
   } phase_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [31:0] start;
      logic [15:0] length;
      logic [30:0] value;
      logic        ovf;
   } res_type;

   typedef struct packed {
      phase_type              phase;
      logic [4:0]             op;
      logic [OFFSET_BITS-1:0] first;
      logic [LENGTH_BITS-1:0] len;
      logic [30:0]            val;
      logic [47:0]            kw;
      logic                   lsat;
      logic                   vsat;
   } tok_type;

   typedef struct packed {
      logic [1:0]    v;
      res_type [1:0] r;
   } fin_type;

   typedef struct packed {
      logic [1:0]    cnt;
      res_type [2:0] slot;
   } bundle_type;

endpackage

FILE: rtl/core/stok_core.sv
module stok_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           char_in,
   input  logic                 byte_valid,
   input  logic                 end_of_input,
   output stok_pkg::bundle_type bundle
);
   import stok_pkg::*;

   typedef struct packed {
      logic       hit;
      logic [5:0] kind;
   } kind_hit_type;

   localparam int NCAND = 7;

   tok_type                tok_ff, tok_in, mid;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, pos_mid;
   logic                   halt_ff, halt_in, mid_halt;
   logic                   consumed;
   logic                   is_ws, is_digit, is_alpha, is_unknown;
   kind_hit_type           punct;
   logic [4:0]             opk;
   res_type                cand [NCAND];
   logic [NCAND-1:0]       cand_v;
   fin_type                fin_byte, fin_end;

   function automatic res_type mk_res(input logic [5:0] kind,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [LENGTH_BITS-1:0] len,
                                      input logic [30:0] val,
                                      input logic ovf);
      res_type r;
      r.kind  = kind;
      r.start = 32'(start);
      r.value = val;
      if (len > LENGTH_BITS'(OUT_LEN_MAX)) begin
         r.length = 16'hFFFF;
         r.ovf    = 1'b1;
      end else begin
         r.length = 16'(len);
         r.ovf    = ovf;
      end
      return r;
   endfunction

   function automatic tok_type grow(input tok_type t);
      tok_type g;
      g = t;
      if (&t.len) g.lsat = 1'b1;
      else g.len = t.len + 1'b1;
      return g;
   endfunction

   function automatic tok_type start_token(input tok_type t,
                                           input logic [OFFSET_BITS-1:0] p);
      tok_type s;
      s       = t;
      s.first = p;
      s.len   = LENGTH_BITS'(1);
      s.lsat  = 1'b0;
      s.vsat  = 1'b0;
      s.val   = '0;
      s.kw    = '0;
      return s;
   endfunction

   function automatic logic [5:0] ident_kind(input tok_type t);
      logic [5:0] k;
      k = KIND_IDENT;
      if (t.len <= LENGTH_BITS'(6)) begin
         for (int i = 0; i < KW_COUNT; i++) begin
            if (t.kw == KW_TEXT[i] && t.len == LENGTH_BITS'(KW_LEN[i])) begin
               k = KIND_KW0 + 6'(i);
            end
         end
      end
      return k;
   endfunction

   // closes whatever token is open; p is the offset of the byte that closes it
   function automatic fin_type finish(input tok_type t,
                                      input logic [OFFSET_BITS-1:0] p);
      fin_type f;
      f = '0;
      unique case (t.phase)
         PH_OPER: begin
            f.v[0] = 1'b1;
            f.r[0] = mk_res(6'(t.op), t.first, LENGTH_BITS'(1), '0, 1'b0);
         end
         PH_SLASH: begin
            f.v[0] = 1'b1;
            f.r[0] = mk_res(KIND_DIV, t.first, LENGTH_BITS'(1), '0, 1'b0);
         end
         PH_STRING: begin
            f.v[0] = 1'b1;
            f.r[0] = mk_res(KIND_ERROR, t.first, t.len, '0, t.lsat);
         end
         PH_INT: begin
            f.v[0] = 1'b1;
            f.r[0] = mk_res(KIND_INT, t.first, t.len, t.val, t.lsat | t.vsat);
         end
         PH_INTDOT: begin
            f.v    = 2'b11;
            f.r[0] = mk_res(KIND_INT, t.first, t.len, t.val, t.lsat | t.vsat);
            f.r[1] = mk_res(KIND_POINT, p - 1'b1, LENGTH_BITS'(1), '0, 1'b0);
         end
         PH_FLOAT: begin
            f.v[0] = 1'b1;
            f.r[0] = mk_res(KIND_FLOAT, t.first, t.len, '0, t.lsat);
         end
         PH_IDENT: begin
            f.v[0] = 1'b1;
            f.r[0] = mk_res(ident_kind(t), t.first, t.len, '0, t.lsat);
         end
         default: f = '0;
      endcase
      return f;
   endfunction

   // byte classes
   always_comb begin
      is_ws    = (char_in == " ") || (char_in == "\t") ||
                 (char_in == "\r") || (char_in == "\n");
      is_digit = (char_in >= "0") && (char_in <= "9");
      is_alpha = ((char_in >= "a") && (char_in <= "z")) ||
                 ((char_in >= "A") && (char_in <= "Z")) || (char_in == "_");
      punct = '0;
      opk   = OP_NONE;
      unique case (char_in)
         "(":     punct = '{1'b1, KIND_LPAREN};
         ")":     punct = '{1'b1, KIND_RPAREN};
         "{":     punct = '{1'b1, KIND_LBRACE};
         "}":     punct = '{1'b1, KIND_RBRACE};
         ",":     punct = '{1'b1, KIND_COMMA};
         ";":     punct = '{1'b1, KIND_SEMI};
         ".":     punct = '{1'b1, KIND_POINT};
         "+":     opk = OP_PLUS;
         "-":     opk = OP_MINUS;
         "*":     opk = OP_STAR;
         "%":     opk = OP_PERCENT;
         "^":     opk = OP_CARET;
         "&":     opk = OP_AMP;
         "|":     opk = OP_BAR;
         "<":     opk = OP_LESS;
         ">":     opk = OP_GREATER;
         "=":     opk = OP_ASSIGN;
         "!":     opk = OP_BANG;
         default: opk = OP_NONE;
      endcase
      is_unknown = !is_ws && !punct.hit && (opk == OP_NONE) && (char_in != "/") &&
                   (char_in != "\"") && !is_digit && !is_alpha;
   end

   // next state: the byte first, then the end marker
   always_comb begin
      logic [34:0] acc;
      mid      = tok_ff;
      mid_halt = halt_ff;
      consumed = 1'b0;
      acc      = 35'(tok_ff.val) * 35'd10 + 35'(char_in - "0");
      pos_mid  = byte_valid ? pos_ff + 1'b1 : pos_ff;
      if (byte_valid && !halt_ff) begin
         unique case (tok_ff.phase)
            PH_OPER: begin
               if (char_in == "=") begin
                  consumed  = 1'b1;
                  mid.phase = PH_IDLE;
               end
            end
            PH_SLASH: begin
               if (char_in == "/") begin
                  consumed  = 1'b1;
                  mid.phase = PH_COMMENT;
               end else if (char_in == "=") begin
                  consumed  = 1'b1;
                  mid.phase = PH_IDLE;
               end
            end
            PH_COMMENT: begin
               consumed = 1'b1;
               if (char_in == "\n") mid.phase = PH_IDLE;
            end
            PH_STRING: begin
               consumed = 1'b1;
               if (char_in == "\"") mid.phase = PH_IDLE;
               else mid = grow(tok_ff);
            end
            PH_INT: begin
               if (is_digit) begin
                  consumed = 1'b1;
                  if (tok_ff.vsat || acc > 35'(VAL_MAX)) begin
                     mid.val  = VAL_MAX;
                     mid.vsat = 1'b1;
                  end else begin
                     mid.val = 31'(acc);
                  end
                  mid = grow(mid);
               end else if (char_in == ".") begin
                  consumed  = 1'b1;
                  mid.phase = PH_INTDOT;
               end
            end
            PH_INTDOT: begin
               if (is_digit) begin
                  consumed  = 1'b1;
                  mid       = grow(grow(tok_ff));
                  mid.phase = PH_FLOAT;
               end
            end
            PH_FLOAT: begin
               if (is_digit) begin
                  consumed = 1'b1;
                  mid      = grow(tok_ff);
               end
            end
            PH_IDENT: begin
               if (is_digit || is_alpha) begin
                  consumed = 1'b1;
                  if (tok_ff.len < LENGTH_BITS'(6)) mid.kw = {tok_ff.kw[39:0], char_in};
                  mid = grow(mid);
               end
            end
            default: consumed = 1'b0;
         endcase
         if (!consumed) begin
            mid.phase = PH_IDLE;
            if (opk != OP_NONE) begin
               mid       = start_token(mid, pos_ff);
               mid.op    = opk;
               mid.phase = PH_OPER;
            end else if (char_in == "/") begin
               mid       = start_token(mid, pos_ff);
               mid.phase = PH_SLASH;
            end else if (char_in == "\"") begin
               // string offsets and lengths cover the content only
               mid       = start_token(mid, pos_ff + 1'b1);
               mid.len   = '0;
               mid.phase = PH_STRING;
            end else if (is_digit) begin
               mid       = start_token(mid, pos_ff);
               mid.val   = 31'(char_in - "0");
               mid.phase = PH_INT;
            end else if (is_alpha) begin
               mid       = start_token(mid, pos_ff);
               mid.kw    = 48'(char_in);
               mid.phase = PH_IDENT;
            end else if (is_unknown) begin
               mid_halt = 1'b1;
            end
         end
      end
      tok_in  = mid;
      halt_in = mid_halt;
      pos_in  = pos_mid;
      if (end_of_input) begin
         tok_in       = '0;
         tok_in.phase = PH_IDLE;
         halt_in      = 1'b0;
         pos_in       = '0;
      end
   end

   // result candidates in emission order
   always_comb begin
      for (int i = 0; i < NCAND; i++) cand[i] = '0;
      cand_v   = '0;
      fin_byte = '0;
      fin_end  = '0;
      if (byte_valid && !halt_ff) begin
         if (consumed) begin
            unique case (tok_ff.phase)
               PH_OPER: begin
                  cand_v[0] = 1'b1;
                  cand[0]   = mk_res(6'(tok_ff.op) + 6'd1, tok_ff.first,
                                     LENGTH_BITS'(2), '0, 1'b0);
               end
               PH_SLASH: begin
                  if (char_in == "=") begin
                     cand_v[0] = 1'b1;
                     cand[0]   = mk_res(KIND_DIV + 6'd1, tok_ff.first,
                                        LENGTH_BITS'(2), '0, 1'b0);
                  end
               end
               PH_STRING: begin
                  if (char_in == "\"") begin
                     cand_v[0] = 1'b1;
                     cand[0]   = mk_res(KIND_STRING, tok_ff.first, tok_ff.len, '0,
                                        tok_ff.lsat);
                  end
               end
               default: cand_v[0] = 1'b0;
            endcase
         end else begin
            fin_byte  = finish(tok_ff, pos_ff);
            cand_v[1] = fin_byte.v[0];
            cand[1]   = fin_byte.r[0];
            cand_v[2] = fin_byte.v[1];
            cand[2]   = fin_byte.r[1];
            if (punct.hit) begin
               cand_v[3] = 1'b1;
               cand[3]   = mk_res(punct.kind, pos_ff, LENGTH_BITS'(1), '0, 1'b0);
            end else if (is_unknown) begin
               cand_v[3] = 1'b1;
               cand[3]   = mk_res(KIND_ERROR, pos_ff, LENGTH_BITS'(1), '0, 1'b0);
            end
         end
      end
      if (end_of_input) begin
         if (!mid_halt) fin_end = finish(mid, pos_mid);
         cand_v[4] = fin_end.v[0];
         cand[4]   = fin_end.r[0];
         cand_v[5] = fin_end.v[1];
         cand[5]   = fin_end.r[1];
         cand_v[6] = 1'b1;
         cand[6]   = mk_res(KIND_EOF, pos_mid, '0, '0, 1'b0);
      end
   end

   // keep the first three candidates
   always_comb begin
      logic [1:0] n;
      n      = '0;
      bundle = '0;
      for (int i = 0; i < NCAND; i++) begin
         if (cand_v[i] && n != 2'd3) begin
            bundle.slot[n] = cand[i];
            n              = n + 2'd1;
         end
      end
      bundle.cnt = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff       <= '0;
         tok_ff.phase <= PH_IDLE;
         pos_ff       <= '0;
         halt_ff      <= 1'b0;
      end else if (step) begin
         tok_ff  <= tok_in;
         pos_ff  <= pos_in;
         halt_ff <= halt_in;
      end
   end

endmodule

FILE: rtl/core/source_tokenizer.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_char_in, req_byte_valid, req_end_of_input
// rsp      out        rsp_valid/rsp_stall  rsp_token_kind .. rsp_overflow, rsp_last
//
// one byte per cycle while req_stall is low: an item is held in the input register until
// the result buffer has room, then the scanner decodes it in a single pass and loads up to
// three tokens into the result buffer, which drains one token per transfer
// the next item waits in the input register until the last token of the item before is taken
// reset is synchronous and clears the scanner state and both buffers
// rsp_stall backs up into req_stall only once the input register is occupied
module source_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_byte_valid,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [31:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [30:0] rsp_int_value,
   output logic        rsp_overflow,
   output logic        rsp_last
);
   import stok_pkg::*;

   // input register
   logic       a_valid_ff;
   logic [7:0] a_char_ff;
   logic       a_bv_ff;
   logic       a_end_ff;

   // result buffer: tokens of one item, rem_ff still to go, rd_ff the next one
   res_type    res_ff [3];
   logic [1:0] rem_ff;
   logic [1:0] rd_ff;

   logic       take, buf_free, advance, accept;
   bundle_type bundle;

   stok_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .char_in      (a_char_ff),
      .byte_valid   (a_bv_ff),
      .end_of_input (a_end_ff),
      .bundle       (bundle)
   );

   // handshake
   assign take     = rsp_valid && !rsp_stall;
   assign buf_free = (rem_ff == 2'd0) || (rem_ff == 2'd1 && take);
   assign advance  = a_valid_ff && buf_free;
   assign req_stall = a_valid_ff && !advance;
   assign accept   = req_valid && !req_stall;

   // output view of the buffer
   assign rsp_valid        = rem_ff != 2'd0;
   assign rsp_last         = rem_ff == 2'd1;
   assign rsp_token_kind   = res_ff[rd_ff].kind;
   assign rsp_token_start  = res_ff[rd_ff].start;
   assign rsp_token_length = res_ff[rd_ff].length;
   assign rsp_int_value    = res_ff[rd_ff].value;
   assign rsp_overflow     = res_ff[rd_ff].ovf;

   // input register, refilled in the cycle it empties
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_char_ff <= req_char_in;
         a_bv_ff   <= req_byte_valid;
         a_end_ff  <= req_end_of_input;
      end
   end

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         rd_ff  <= '0;
      end else if (advance && bundle.cnt != 2'd0) begin
         rem_ff <= bundle.cnt;
         rd_ff  <= '0;
      end else if (take) begin
         rem_ff <= rem_ff - 2'd1;
         rd_ff  <= rd_ff + 2'd1;
      end
   end

   // token payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance && bundle.cnt != 2'd0) begin
         res_ff[0] <= bundle.slot[0];
         res_ff[1] <= bundle.slot[1];
         res_ff[2] <= bundle.slot[2];
      end
   end

endmodule
